FILE: hw/rtl/assert_macros.svh
// assertion macros for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/rau_pkg.sv
// types, constants and codes of the fraction arithmetic unit
package rau_pkg;
    localparam int unsigned FieldW = 32;
    localparam int unsigned DefaultWidth = 32;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CMP  = 3'd4,
        OP_SIMP = 3'd5,
        OP_NOP6 = 3'd6,
        OP_NOP7 = 3'd7
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic signed [31:0] res_den;
        logic               equal;
        logic               den_zero;
    } t_out_beat;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_Q1_START,
        ST_Q1_WAIT,
        ST_Q2_START,
        ST_Q2_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } t_state;
endpackage

FILE: hw/rtl/rational_arithmetic_unit_core.sv
// top level of the fraction arithmetic unit
// usage:
//   drive i_in and raise start while busy is low; that edge takes the beat.
//   busy stays high until the result has been computed.
//   o_valid pulses for one cycle with o_out holding the result beat; the
//   receiver cannot hold it off and must take it in that cycle.
// sequence:
//   compare and the unused codes go straight to the result; multiply and
//   divide pass two product steps first. add, subtract and simplify run
//   euclid's gcd on the shared 32-step divider (at most about 46 remainder
//   steps), then two more divisions for the scale factors (for simplify,
//   the reduced fraction) and the two product steps.
// throughput: one item at a time, the next start is taken once busy falls.
// reset: synchronous active low on i_rst_n; the sequencer returns to idle and
// no result is pending.
module rational_arithmetic_unit_core #(
    parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rau_pkg::t_in_beat  i_in,
    output logic               o_valid,
    output rau_pkg::t_out_beat o_out
);
    import rau_pkg::*;

    t_div_req w_req;
    t_div_rsp w_rsp;

    rau_sequencer #(.WIDTH(WIDTH)) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_in   (i_in),
        .o_busy (busy),
        .o_req  (w_req),
        .i_rsp  (w_rsp),
        .o_done (o_valid),
        .o_out  (o_out)
    );

    rau_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );
endmodule

FILE: hw/rtl/rau_divider.sv
// restoring shift-subtract divider, one quotient bit per cycle
module rau_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_div_req i_req,
    output rau_pkg::t_div_rsp o_rsp
);
    import rau_pkg::*;

    localparam int unsigned CntW = $clog2(FieldW + 1);

    logic [31:0]     r_quot, n_quot;
    logic [31:0]     r_rem, n_rem;
    logic [31:0]     r_dsr, n_dsr;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [32:0]     w_trial;

    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = '0;
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
            n_cnt  = CntW'(FieldW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            w_trial = {r_rem, r_quot[31]} - {1'b0, r_dsr};
            if (!w_trial[32]) begin
                n_rem  = w_trial[31:0];
                n_quot = {r_quot[30:0], 1'b1};
            end else begin
                n_rem  = {r_rem[30:0], r_quot[31]};
                n_quot = {r_quot[30:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;
endmodule

FILE: hw/rtl/rau_sequencer.sv
// operation sequencer: euclid loop and scale factors over the divider, then the products
module rau_sequencer #(
    parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rau_pkg::t_in_beat  i_in,
    output logic               o_busy,
    output rau_pkg::t_div_req  o_req,
    input  rau_pkg::t_div_rsp  i_rsp,
    output logic               o_done,
    output rau_pkg::t_out_beat o_out
);
    import rau_pkg::*;

    t_state      r_state, n_state;
    t_op         r_op;
    logic [31:0] r_an, r_bn, r_d1, r_d2;
    logic [31:0] r_x, r_y;
    logic [31:0] r_g, r_q1, r_q2;
    logic [63:0] r_p1, r_p2;
    logic [63:0] r_num, r_den;
    logic        r_eq;
    logic        r_done;
    t_out_beat   r_out;

    logic [31:0] w_mag;
    logic [63:0] w_num, w_den;
    logic [63:0] w_wn, w_wd;
    logic        w_arith;

    function automatic logic [31:0] norm_den(input logic [31:0] d);
        norm_den = ($signed(d) > 0) ? d : 32'd1;
    endfunction

    function automatic logic [63:0] wrap(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        for (int i = 0; i < 64; i++) begin
            if (i >= WIDTH) r[i] = v[WIDTH-1];
        end
        wrap = r;
    endfunction

    assign w_mag = r_an[31] ? (32'd0 - r_an) : r_an;
    assign w_arith = (r_op != OP_CMP) && (r_op != OP_NOP6) && (r_op != OP_NOP7);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_in.op)
                        OP_ADD, OP_SUB, OP_SIMP: n_state = ST_GCD_START;
                        OP_MUL, OP_DIV:          n_state = ST_MUL1;
                        default:                 n_state = ST_DONE;
                    endcase
                end
            end
            ST_GCD_START: n_state = (r_y == '0) ? ST_Q1_START : ST_GCD_WAIT;
            ST_GCD_WAIT:  if (i_rsp.done) n_state = ST_GCD_START;
            ST_Q1_START:  n_state = ST_Q1_WAIT;
            ST_Q1_WAIT:   if (i_rsp.done) n_state = ST_Q2_START;
            ST_Q2_START:  n_state = ST_Q2_WAIT;
            ST_Q2_WAIT:   if (i_rsp.done) n_state = ST_MUL1;
            ST_MUL1:      n_state = ST_MUL2;
            ST_MUL2:      n_state = ST_DONE;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req = '0;
        unique case (r_state)
            ST_GCD_START: begin
                o_req.start    = (r_y != '0);
                o_req.dividend = r_x;
                o_req.divisor  = r_y;
            end
            ST_Q1_START: begin
                o_req.start    = 1'b1;
                o_req.dividend = (r_op == OP_SIMP) ? w_mag : r_d2;
                o_req.divisor  = r_g;
            end
            ST_Q2_START: begin
                o_req.start    = 1'b1;
                o_req.dividend = r_d1;
                o_req.divisor  = r_g;
            end
            default: o_req = '0;
        endcase
    end

    // final combine of the registered products, or of the quotients for simplify
    always_comb begin
        unique case (r_op)
            OP_ADD:  w_num = r_p1 + r_p2;
            OP_SUB:  w_num = r_p1 - r_p2;
            OP_SIMP: w_num = r_an[31] ? (64'd0 - {32'd0, r_q1}) : {32'd0, r_q1};
            default: w_num = r_p1;
        endcase
        unique case (r_op)
            OP_ADD, OP_SUB: w_den = r_num;
            OP_SIMP:        w_den = {32'd0, r_q2};
            default:        w_den = r_p2;
        endcase
        w_wn = wrap(w_num);
        w_wd = wrap(w_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_DONE);
        end
        unique case (r_state)
            ST_IDLE: begin
                r_op <= i_in.op;
                r_an <= i_in.a_num;
                r_bn <= i_in.b_num;
                r_d1 <= norm_den(i_in.a_den);
                r_d2 <= norm_den(i_in.b_den);
                r_x  <= (i_in.op == OP_SIMP)
                     ? (i_in.a_num[31] ? (32'd0 - i_in.a_num) : i_in.a_num)
                     : norm_den(i_in.a_den);
                r_y  <= (i_in.op == OP_SIMP) ? norm_den(i_in.a_den)
                                             : norm_den(i_in.b_den);
                r_eq <= (i_in.a_num == i_in.b_num)
                     && (norm_den(i_in.a_den) == norm_den(i_in.b_den));
            end
            ST_GCD_START: r_g <= r_x;
            ST_GCD_WAIT: begin
                if (i_rsp.done) begin
                    r_x <= r_y;
                    r_y <= i_rsp.rem;
                end
            end
            ST_Q1_WAIT: if (i_rsp.done) r_q1 <= i_rsp.quot;
            ST_Q2_WAIT: if (i_rsp.done) r_q2 <= i_rsp.quot;
            ST_MUL1: begin
                unique case (r_op)
                    OP_MUL: begin
                        r_p1 <= 64'($signed(r_an) * $signed(r_bn));
                        r_p2 <= 64'(r_d1 * r_d2);
                    end
                    OP_DIV: begin
                        r_p1 <= 64'($signed(r_an) * $signed({1'b0, r_d2}));
                        r_p2 <= 64'($signed({1'b0, r_d1}) * $signed(r_bn));
                    end
                    default: begin
                        r_p1 <= 64'($signed({1'b0, r_q1}) * $signed(r_an));
                        r_p2 <= 64'($signed({1'b0, r_q2}) * $signed(r_bn));
                    end
                endcase
            end
            ST_MUL2: r_num <= 64'(r_d1 * r_q1);
            ST_DONE: begin
                r_out.res_num  <= w_arith ? w_wn[31:0] : 32'd0;
                r_out.res_den  <= w_arith ? w_wd[31:0] : 32'd0;
                r_out.equal    <= (r_op == OP_CMP) ? r_eq : 1'b0;
                r_out.den_zero <= w_arith && (w_wd == '0);
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;
endmodule

FILE: hw/rtl/rau_checker.sv
// port checker for the fraction arithmetic unit, bound to the top level
`include "assert_macros.svh"
module rau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input rau_pkg::t_out_beat o_out
);
    import rau_pkg::*;

    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_IMPL(a_eq_flags, i_clk, i_rst_n, o_valid && o_out.equal, !o_out.den_zero)
    `ASSERT_IMPL(a_dz_den, i_clk, i_rst_n, o_valid && o_out.den_zero, o_out.res_den == '0)
endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid),
    .o_out  (o_out)
);

FILE: tb/tb_rational_arithmetic_unit_core.sv
// testbench of the fraction arithmetic unit: directed and random beats checked against a predictor
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit_core;
    import rau_pkg::*;

    localparam int unsigned WIDTH = 32;
    localparam int unsigned CycleLimit = 12_000_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_beat  i_in;
    logic      o_valid;
    t_out_beat o_out;

    t_in_beat  pending_ops[$];
    t_out_beat expected_results[$];
    int unsigned mismatch_count;
    int unsigned result_count;
    int unsigned cycle_count;
    int unsigned gap_left;
    bit          stim_done;

    rational_arithmetic_unit_core #(.WIDTH(WIDTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] norm_den(logic signed [31:0] d);
        return (d > 0) ? 64'(d) : 64'd1;
    endfunction

    function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_out_beat fraction_result(t_in_beat x);
        t_out_beat r;
        logic [63:0] ua, ub, d1, d2, g, q1, q2, mag, num, den;
        logic arith;
        ua = 64'(x.a_num);
        ub = 64'(x.b_num);
        d1 = norm_den(x.a_den);
        d2 = norm_den(x.b_den);
        num = 0;
        den = 0;
        arith = 1'b1;
        r = '0;
        case (x.op)
            OP_ADD, OP_SUB: begin
                g = euclid_gcd(d1, d2);
                q1 = d2 / g;
                q2 = d1 / g;
                den = d1 * q1;
                num = (x.op == OP_ADD) ? q1 * ua + q2 * ub : q1 * ua - q2 * ub;
            end
            OP_MUL: begin
                num = ua * ub;
                den = d1 * d2;
            end
            OP_DIV: begin
                num = ua * d2;
                den = d1 * ub;
            end
            OP_CMP: begin
                r.equal = (x.a_num == x.b_num) && (d1 == d2);
                arith = 1'b0;
            end
            OP_SIMP: begin
                mag = (x.a_num < 0) ? -ua : ua;
                g = euclid_gcd(mag, d1);
                num = (x.a_num < 0) ? -(mag / g) : mag / g;
                den = d1 / g;
            end
            default: arith = 1'b0;
        endcase
        if (arith) begin
            r.res_num = num[31:0];
            r.res_den = den[31:0];
            r.den_zero = (den[31:0] == 0);
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d, %s: got %h expected %h",
                 result_count, field, got, want);
        mismatch_count++;
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 20));
            1: return -32'($urandom_range(0, 20));
            2: return 32'($urandom_range(1, 5000)) * 32'($urandom_range(1, 12));
            3: return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned rand_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    task automatic add_item(t_op op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
        t_in_beat x;
        x.op = op;
        x.a_num = an;
        x.a_den = ad;
        x.b_num = bn;
        x.b_den = bd;
        pending_ops.push_back(x);
    endtask

    initial begin
        t_in_beat x;
        mismatch_count = 0;
        result_count = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        for (int k = 0; k < 8; k++) begin
            add_item(t_op'(k), 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        end
        add_item(OP_ADD, 1, 6, 1, 4);
        add_item(OP_SUB, -5, 0, 3, -7);
        add_item(OP_MUL, 32'hffffffff, 32'h7fffffff, 32'hffffffff, 32'h7fffffff);
        add_item(OP_DIV, 3, 4, 0, 5);
        add_item(OP_DIV, 1, 65536, 65536, 1);
        add_item(OP_MUL, 1, 65536, 1, 65536);
        add_item(OP_CMP, 7, 0, 7, 1);
        add_item(OP_CMP, 7, 3, 7, 4);
        add_item(OP_SIMP, 0, 9, 0, 0);
        add_item(OP_SIMP, -12, 18, 0, 0);
        add_item(OP_SIMP, 32'h80000000, 32'h40000000, 0, 0);
        add_item(OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7ffffffe);
        add_item(OP_SUB, 0, 1, 0, 1);
        add_item(OP_NOP6, 1, 2, 3, 4);
        for (int k = 0; k < 1550; k++) begin
            x.op = t_op'($urandom_range(0, 7));
            x.a_num = rand_field();
            x.a_den = rand_field();
            x.b_num = rand_field();
            x.b_den = rand_field();
            if (x.op == OP_CMP && $urandom_range(0, 1)) begin
                x.b_num = x.a_num;
                x.b_den = x.a_den;
            end
            pending_ops.push_back(x);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_results.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("checked %0d results over all eight op codes, edge values and random fractions",
                 result_count);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // driver
    initial begin
        start = 1'b0;
        i_in = '0;
        gap_left = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_results.push_back(fraction_result(i_in));
            gap_left = rand_gap();
            if (pending_ops.size() != 0 && gap_left == 0) begin
                i_in <= pending_ops.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
                if (pending_ops.size() == 0) stim_done = 1'b1;
            end
        end else if (!start) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_ops.size() != 0) begin
                i_in <= pending_ops.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_beat want;
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out.res_num !== want.res_num)
                    report_mismatch("res_num", o_out.res_num, want.res_num);
                if (o_out.res_den !== want.res_den)
                    report_mismatch("res_den", o_out.res_den, want.res_den);
                if (o_out.equal !== want.equal)
                    report_mismatch("equal", 32'(o_out.equal), 32'(want.equal));
                if (o_out.den_zero !== want.den_zero)
                    report_mismatch("den_zero", 32'(o_out.den_zero), 32'(want.den_zero));
            end
            result_count++;
        end
    end

    initial cycle_count = 0;
endmodule
